// ===== hw/rtl/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg
// shared types and constants for the max-heap priority queue
// ----------------------------------------------------------------------------
package hpq_pkg;

	localparam int KEY_W    = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 8;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 48;

	typedef logic signed [KEY_W-1:0] key_t;

	localparam logic FUNC_INSERT  = 1'b0;
	localparam logic FUNC_EXTRACT = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b0000000001,
		S_UP_RD   = 10'b0000000010,
		S_UP_CMP  = 10'b0000000100,
		S_UP_FIN  = 10'b0000001000,
		S_EX_ROOT = 10'b0000010000,
		S_EX_LAST = 10'b0000100000,
		S_DN_RDL  = 10'b0001000000,
		S_DN_RDR  = 10'b0010000000,
		S_DN_CMP  = 10'b0100000000,
		S_DONE    = 10'b1000000000
	} state_t;

endpackage

// ===== hw/rtl/hpq_mem.sv =====
// ----------------------------------------------------------------------------
// hpq_mem
// heap store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module hpq_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  hpq_pkg::key_t        wdata,
	input  logic [AW-1:0]        raddr,
	output hpq_pkg::key_t        rdata
);
	import hpq_pkg::*;

	key_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// binary max-heap over signed 32-bit keys, one transaction in, one out
// ----------------------------------------------------------------------------
// Keys live in a single synchronous memory in level order (root at entry 0).
// One operation is worked on at a time. An insert reads the parent and
// compares with it for each level climbed, and writes the key where it
// stops. An extract reads the root, then the last entry, then for each level
// descended reads the left child, then the right child and compares; it skips
// the descent when it empties the heap. Extract from an empty heap and insert
// into a full one go straight to the result. The time is set by the single
// read port of the store (one read per cycle, registered read data), and a
// result also waits while the output register is still held. The next
// operation may be accepted in the cycle after the result is loaded.
// Extract from an empty heap and insert into a full one leave the heap as it
// is and report a status code. No clearing pass is needed after reset.
module max_heap_priority_queue #(
	parameter int CAPACITY = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // func[0], key_in[32:1], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // key_out[31:0], status[33:32], count_out[41:34], zero pad
);
	import hpq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = AW + 2;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         pos_q;
	key_t                  key_q;
	key_t                  lval_q;
	key_t                  res_key_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	key_t                  mem_wdata;
	logic [AW-1:0]         mem_raddr;
	key_t                  mem_rdata;

	logic                  in_func;
	key_t                  in_key;
	logic                  accept;
	logic [AW-1:0]         parent;
	logic [LW-1:0]         lidx;
	logic [LW-1:0]         ridx;
	logic [LW-1:0]         n_ext;
	logic                  l_in;
	logic                  r_in;
	logic                  l_gt;
	key_t                  big_val;
	logic                  r_gt;
	logic [CW+COUNT_W-1:0] count_ext;
	logic                  out_free;

	assign in_func   = s_axis_tdata[0];
	assign in_key    = s_axis_tdata[KEY_W:1];
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept    = s_axis_tvalid && s_axis_tready;

	assign parent    = AW'((pos_q - AW'(1)) >> 1);
	assign lidx      = LW'({pos_q, 1'b1});
	assign ridx      = lidx + LW'(1);
	assign n_ext     = LW'(count_q);
	assign l_in      = lidx < n_ext;
	assign r_in      = ridx < n_ext;
	assign l_gt      = lval_q > key_q;
	assign big_val   = l_gt ? lval_q : key_q;
	assign r_gt      = r_in && (mem_rdata > big_val);
	assign count_ext = {{COUNT_W{1'b0}}, count_q};
	assign out_free  = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	hpq_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// read address and write port
	always_comb begin
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = key_q;
		unique case (state_q)
			S_UP_RD:   mem_raddr = parent;
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (key_q > mem_rdata) begin
					mem_wdata = mem_rdata;
				end
			end
			S_UP_FIN:  mem_we = 1'b1;
			S_EX_ROOT: mem_raddr = count_q[AW-1:0];
			S_DN_RDL: begin
				mem_raddr = lidx[AW-1:0];
				mem_we    = !l_in;
			end
			S_DN_RDR:  mem_raddr = ridx[AW-1:0];
			S_DN_CMP: begin
				mem_we = 1'b1;
				if (r_gt) begin
					mem_wdata = mem_rdata;
				end else if (l_gt) begin
					mem_wdata = lval_q;
				end
			end
			default:   mem_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_func == FUNC_INSERT) begin
							if (count_q == CAP_C) begin
								state_q <= S_DONE;
							end else begin
								count_q <= count_q + CW'(1);
								state_q <= (count_q == '0) ? S_UP_FIN : S_UP_RD;
							end
						end else begin
							if (count_q == '0) begin
								state_q <= S_DONE;
							end else begin
								count_q <= count_q - CW'(1);
								state_q <= S_EX_ROOT;
							end
						end
					end
				end
				S_UP_RD:   state_q <= S_UP_CMP;
				S_UP_CMP: begin
					if (key_q > mem_rdata) begin
						state_q <= (parent == '0) ? S_UP_FIN : S_UP_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_UP_FIN:  state_q <= S_DONE;
				S_EX_ROOT: state_q <= S_EX_LAST;
				S_EX_LAST: state_q <= (count_q == '0) ? S_DONE : S_DN_RDL;
				S_DN_RDL:  state_q <= l_in ? S_DN_RDR : S_DONE;
				S_DN_RDR:  state_q <= S_DN_CMP;
				S_DN_CMP:  state_q <= (r_gt || l_gt) ? S_DN_RDL : S_DONE;
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				key_q        <= in_key;
				pos_q        <= count_q[AW-1:0];
				res_key_q    <= '0;
				res_status_q <= ST_OK;
				if (in_func == FUNC_INSERT && count_q == CAP_C) begin
					res_status_q <= ST_FULL;
				end
				if (in_func == FUNC_EXTRACT && count_q == '0) begin
					res_status_q <= ST_EMPTY;
				end
			end
			S_UP_CMP: begin
				if (key_q > mem_rdata) begin
					pos_q <= parent;
				end
			end
			S_EX_ROOT: res_key_q <= mem_rdata;
			S_EX_LAST: begin
				key_q <= mem_rdata;
				pos_q <= '0;
			end
			S_DN_RDR:  lval_q <= mem_rdata;
			S_DN_CMP: begin
				if (r_gt) begin
					pos_q <= ridx[AW-1:0];
				end else if (l_gt) begin
					pos_q <= lidx[AW-1:0];
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_data_q <= OUT_W'({count_ext[COUNT_W-1:0], res_status_q, res_key_q});
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/max_heap_priority_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_test
// self-checking testbench for the max-heap priority queue
// ----------------------------------------------------------------------------
// Each accepted transaction is run through a behavioural max-heap that is kept
// alongside the block. The expected key, status and count go into a queue, and
// every result transaction is checked against the oldest entry. Directed
// cases cover key extremes, ties and the empty and full conditions. Random
// phases then swing the occupancy between empty and full, with random gaps
// on both streams.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_test;

	import hpq_pkg::*;

	localparam int   DEPTH      = 128;
	localparam int   N_RANDOM   = 850;
	localparam int   MAX_PRINTS = 50;
	localparam key_t KEY_MAX    = 32'h7fff_ffff;
	localparam key_t KEY_MIN    = 32'h8000_0000;

	typedef struct packed {
		key_t                key;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} heap_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;  // func[0], key_in[32:1], zero pad
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;  // key_out[31:0], status[33:32], count_out[41:34], zero pad

	key_t         heap_keys [DEPTH];
	int           heap_count;
	heap_result_t pending_results [$];

	bit no_idle;
	int mismatch_count;
	int results_checked;
	int n_insert, n_extract, n_empty, n_full, peak_count;

	max_heap_priority_queue #(
		.CAPACITY(DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#10_000_000;
		$display("timeout: %0d results still outstanding", pending_results.size());
		$display("Simulation FAILED");
		$finish;
	end

	function automatic heap_result_t heap_insert(input key_t key);
		heap_result_t r;
		int           pos;
		int           up;
		key_t         t;
		r.key    = '0;
		r.status = ST_OK;
		if (heap_count >= DEPTH) begin
			r.status = ST_FULL;
		end else begin
			heap_keys[heap_count] = key;
			pos = heap_count;
			while (pos > 0) begin
				up = (pos - 1) / 2;
				if (!(heap_keys[pos] > heap_keys[up]))
					break;
				t              = heap_keys[pos];
				heap_keys[pos] = heap_keys[up];
				heap_keys[up]  = t;
				pos            = up;
			end
			heap_count++;
		end
		r.count = COUNT_W'(heap_count);
		return r;
	endfunction

	function automatic heap_result_t heap_extract();
		heap_result_t r;
		int           pos;
		int           lc;
		int           rc;
		int           big;
		key_t         t;
		r.key    = '0;
		r.status = ST_OK;
		if (heap_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.key = heap_keys[0];
			heap_count--;
			heap_keys[0] = heap_keys[heap_count];
			pos = 0;
			while (1) begin
				lc  = 2 * pos + 1;
				rc  = lc + 1;
				big = pos;
				if (lc < heap_count && heap_keys[lc] > heap_keys[big])
					big = lc;
				if (rc < heap_count && heap_keys[rc] > heap_keys[big])
					big = rc;
				if (big == pos)
					break;
				t               = heap_keys[pos];
				heap_keys[pos]  = heap_keys[big];
				heap_keys[big]  = t;
				pos             = big;
			end
		end
		r.count = COUNT_W'(heap_count);
		return r;
	endfunction

	// mostly full-range keys, with a share of small values for ties and of extremes
	function automatic key_t rand_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return key_t'($urandom);
			6, 7:             return key_t'(int'($urandom_range(0, 16)) - 8);
			8:                return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
			default: begin
				if ($urandom_range(0, 1))
					return KEY_MAX - key_t'($urandom_range(0, 3));
				return KEY_MIN + key_t'($urandom_range(0, 3));
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// valid is left high after acceptance so back-to-back transactions need no gap
	task automatic send_op(input logic func, input key_t key);
		int           gap;
		heap_result_t r;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'b0, key, func};
		do @(posedge clk); while (!s_axis_tready);
		if (func == FUNC_INSERT) begin
			r = heap_insert(key);
			n_insert++;
		end else begin
			r = heap_extract();
			n_extract++;
		end
		if (r.status == ST_EMPTY)
			n_empty++;
		if (r.status == ST_FULL)
			n_full++;
		if (heap_count > peak_count)
			peak_count = heap_count;
		pending_results.push_back(r);
	endtask

	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	initial begin : result_checker
		heap_result_t        want;
		key_t                got_key;
		logic [STATUS_W-1:0] got_status;
		logic [COUNT_W-1:0]  got_count;
		int                  stall;
		m_axis_tready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got_key    = m_axis_tdata[31:0];
			got_status = m_axis_tdata[33:32];
			got_count  = m_axis_tdata[41:34];
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result key %0d status %0d count %0d",
					got_key, got_status, got_count));
			end else begin
				want = pending_results.pop_front();
				if (got_key !== want.key)
					report_mismatch($sformatf("result %0d key_out %0d, expected %0d",
						results_checked, got_key, want.key));
				if (got_status !== want.status)
					report_mismatch($sformatf("result %0d status %0d, expected %0d",
						results_checked, got_status, want.status));
				if (got_count !== want.count)
					report_mismatch($sformatf("result %0d count_out %0d, expected %0d",
						results_checked, got_count, want.count));
			end
			results_checked++;
		end
	end

	// extremes, alternating bit patterns and ties, then drain past empty
	task automatic test_directed();
		send_op(FUNC_EXTRACT, KEY_MAX);
		send_op(FUNC_INSERT, KEY_MAX);
		send_op(FUNC_INSERT, KEY_MIN);
		send_op(FUNC_INSERT, '0);
		send_op(FUNC_INSERT, -1);
		send_op(FUNC_INSERT, 1);
		send_op(FUNC_INSERT, 5);
		send_op(FUNC_INSERT, 5);
		send_op(FUNC_INSERT, 5);
		send_op(FUNC_INSERT, 32'h5555_5555);
		send_op(FUNC_INSERT, 32'haaaa_aaaa);
		repeat (11) send_op(FUNC_EXTRACT, -1);
		wait_for_results();
	endtask

	task automatic test_full();
		while (heap_count < DEPTH)
			send_op(FUNC_INSERT, rand_key());
		send_op(FUNC_INSERT, KEY_MAX);
		send_op(FUNC_INSERT, KEY_MIN);
		wait_for_results();
		repeat (3) send_op(FUNC_EXTRACT, rand_key());
		repeat (3) send_op(FUNC_INSERT, rand_key());
		send_op(FUNC_INSERT, rand_key());
		while (heap_count > 0)
			send_op(FUNC_EXTRACT, rand_key());
		send_op(FUNC_EXTRACT, rand_key());
		wait_for_results();
	endtask

	// phases lean towards filling, draining or balance so occupancy sweeps its range
	task automatic test_random(input int n_items);
		int   i;
		int   bias;
		int   pick;
		logic func;
		bias = 0;
		for (i = 0; i < n_items; i++) begin
			if (i % 100 == 0) begin
				bias    = $urandom_range(0, 2);
				no_idle = ($urandom_range(0, 3) == 0);
			end
			if (i % 350 == 349)
				wait_for_results();
			pick = $urandom_range(0, 9);
			case (bias)
				0:       func = (pick < 8) ? FUNC_INSERT : FUNC_EXTRACT;
				1:       func = (pick < 8) ? FUNC_EXTRACT : FUNC_INSERT;
				default: func = (pick < 5) ? FUNC_INSERT : FUNC_EXTRACT;
			endcase
			send_op(func, rand_key());
		end
		no_idle = 1'b0;
		wait_for_results();
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		no_idle        = 1'b0;
		heap_count     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full();
		test_random(N_RANDOM);
		no_idle = 1'b1;
		test_full();

		wait_for_results();
		repeat (64) @(posedge clk);
		$display("covered %0d inserts and %0d extracts, %0d results checked",
			n_insert, n_extract, results_checked);
		$display("extracts when empty: %0d, inserts when full: %0d, peak occupancy %0d",
			n_empty, n_full, peak_count);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
